// ===== rtl/core/tvdbp_pkg.sv =====
package tvdbp_pkg;

   localparam int COMP_WIDTH = 16;
   localparam int FRAC_BITS  = 11;
   localparam int SCALE_FRAC = 12;
   localparam int SCALE_W    = 16;
   localparam int NCOMP      = 6;
   localparam int NLANE      = 2 * NCOMP;

   localparam int SQ_W       = 2 * COMP_WIDTH;
   localparam int SUM_W      = 2 * COMP_WIDTH + 4;
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int NORM_W     = ROOT_STEPS;
   localparam int DEN_W      = SCALE_W + NORM_W;
   localparam int ONE_SHIFT  = FRAC_BITS + SCALE_FRAC;
   localparam int QW         = COMP_WIDTH;
   localparam int NUM_W      = COMP_WIDTH + ONE_SHIFT + 1;

   localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1) << ONE_SHIFT;
   localparam logic [QW-1:0] POS_MAX = QW'((1 << (COMP_WIDTH - 1)) - 1);
   localparam logic [QW-1:0] NEG_MAX = QW'(1 << (COMP_WIDTH - 1));

   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_SCALE = 1'b1;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4096);

   typedef enum logic [1:0] {
      MODE_TWO   = 2'd0,
      MODE_SYM2  = 2'd1,
      MODE_THREE = 2'd2,
      MODE_SIX   = 2'd3
   } mode_type;

   typedef logic signed [COMP_WIDTH-1:0] comp_type;
   typedef comp_type [NCOMP-1:0] vec_type;

   function automatic logic lane_used(mode_type mode, int unsigned k);
      logic r;
      case (mode)
         MODE_TWO:   r = (k < 2);
         MODE_SYM2:  r = (k < 3);
         MODE_THREE: r = (k < 3);
         default:    r = (k < NCOMP);
      endcase
      return r;
   endfunction

   function automatic logic lane_double(mode_type mode, int unsigned k);
      logic r;
      case (mode)
         MODE_TWO:  r = (k >= 2);
         MODE_SYM2: r = (k >= 2);
         default:   r = (k >= 3);
      endcase
      return r;
   endfunction

   function automatic logic [COMP_WIDTH-1:0] mag(comp_type c);
      logic [COMP_WIDTH-1:0] r;
      r = c[COMP_WIDTH-1] ? COMP_WIDTH'(-c) : COMP_WIDTH'(c);
      return r;
   endfunction

endpackage

// ===== rtl/core/tv_dual_ball_projection.sv =====
// Projects one pixel's dual vector (six complex Q4.11 components) onto the
// ball of radius 1/shrink_scale. Each used component is divided by
// max(shrink_scale * floor(sqrt(weighted sum of squares)), 1.0).
// Request channel: req_valid / req_stall with the twelve component fields.
// An item is taken at a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with the twelve projected fields;
// unused components come out as zero.
// Pipeline order: squares and sum, bit-per-stage square root, scale, clamp
// and numerator setup, bit-per-stage dividers, output register.
// Throughput: one item per cycle while rsp_stall is low; every stage carries its own valid bit.
// When rsp_stall is high the held result stays put, stages behind it keep
// filling any empty slots, and req_stall rises only when the stage at the
// front is full and cannot move.
// Reset (synchronous) empties the pipeline and sets component_mode to
// three plain components and shrink_scale to 1.0. Write csr registers
// only while no item is in flight.
module tv_dual_ball_projection (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_index,
   input  logic [tvdbp_pkg::SCALE_W-1:0]        csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c0_re,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c0_im,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c1_re,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c1_im,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c2_re,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c2_im,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c3_re,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c3_im,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c4_re,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c4_im,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c5_re,
   input  logic signed [tvdbp_pkg::COMP_WIDTH-1:0] req_c5_im,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o0_re,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o0_im,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o1_re,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o1_im,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o2_re,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o2_im,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o3_re,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o3_im,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o4_re,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o4_im,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o5_re,
   output logic signed [tvdbp_pkg::COMP_WIDTH-1:0] rsp_o5_im
);

   tvdbp_pkg::mode_type mode_ff;
   logic [tvdbp_pkg::SCALE_W-1:0] scale_ff;

   tvdbp_pkg::vec_type req_re, req_im;
   tvdbp_pkg::vec_type sq_re, sq_im, rt_re, rt_im, res_re, res_im;
   tvdbp_pkg::mode_type sq_mode, rt_mode;
   logic [tvdbp_pkg::SUM_W-1:0] sq_sum;
   logic [tvdbp_pkg::NORM_W-1:0] rt_norm;
   logic in_ready, sq_valid, sq_ready, rt_valid, rt_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tvdbp_pkg::MODE_THREE;
         scale_ff <= tvdbp_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            tvdbp_pkg::CSR_MODE:  mode_ff  <= tvdbp_pkg::mode_type'(csr_wdata[1:0]);
            tvdbp_pkg::CSR_SCALE: scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_re = {req_c5_re, req_c4_re, req_c3_re, req_c2_re, req_c1_re, req_c0_re};
   assign req_im = {req_c5_im, req_c4_im, req_c3_im, req_c2_im, req_c1_im, req_c0_im};
   assign req_stall = !in_ready;

   tvdbp_sumsq u_sumsq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_re     (req_re),
      .in_im     (req_im),
      .in_mode   (mode_ff),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_re    (sq_re),
      .out_im    (sq_im),
      .out_mode  (sq_mode),
      .out_sum   (sq_sum)
   );

   tvdbp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_re     (sq_re),
      .in_im     (sq_im),
      .in_mode   (sq_mode),
      .in_sum    (sq_sum),
      .out_valid (rt_valid),
      .out_ready (rt_ready),
      .out_re    (rt_re),
      .out_im    (rt_im),
      .out_mode  (rt_mode),
      .out_norm  (rt_norm)
   );

   tvdbp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_ready  (rt_ready),
      .in_re     (rt_re),
      .in_im     (rt_im),
      .in_mode   (rt_mode),
      .in_norm   (rt_norm),
      .scale     (scale_ff),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_re    (res_re),
      .out_im    (res_im)
   );

   assign rsp_o0_re = res_re[0];
   assign rsp_o0_im = res_im[0];
   assign rsp_o1_re = res_re[1];
   assign rsp_o1_im = res_im[1];
   assign rsp_o2_re = res_re[2];
   assign rsp_o2_im = res_im[2];
   assign rsp_o3_re = res_re[3];
   assign rsp_o3_im = res_im[3];
   assign rsp_o4_re = res_re[4];
   assign rsp_o4_im = res_im[4];
   assign rsp_o5_re = res_re[5];
   assign rsp_o5_im = res_im[5];

endmodule

// ===== rtl/core/tvdbp_sumsq.sv =====
module tvdbp_sumsq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  tvdbp_pkg::vec_type        in_re,
   input  tvdbp_pkg::vec_type        in_im,
   input  tvdbp_pkg::mode_type       in_mode,
   output logic                      out_valid,
   input  logic                      out_ready,
   output tvdbp_pkg::vec_type        out_re,
   output tvdbp_pkg::vec_type        out_im,
   output tvdbp_pkg::mode_type       out_mode,
   output logic [tvdbp_pkg::SUM_W-1:0] out_sum
);

   logic en0, en1;
   logic s0_vld_ff, s1_vld_ff;
   tvdbp_pkg::vec_type s0_re_ff, s0_im_ff, s1_re_ff, s1_im_ff;
   tvdbp_pkg::mode_type s0_mode_ff, s1_mode_ff;
   logic [tvdbp_pkg::SQ_W-1:0] sq_in [tvdbp_pkg::NCOMP];
   logic [tvdbp_pkg::SQ_W-1:0] sq_ff [tvdbp_pkg::NCOMP];
   logic [tvdbp_pkg::SUM_W-1:0] sum_in, sum_ff;

   assign en1 = !s1_vld_ff | out_ready;
   assign en0 = !s0_vld_ff | en1;
   assign in_ready = en0;

   always_comb begin
      logic [tvdbp_pkg::SQ_W-1:0] mr, mi;
      for (int k = 0; k < tvdbp_pkg::NCOMP; k++) begin
         mr = tvdbp_pkg::SQ_W'(tvdbp_pkg::mag(in_re[k]));
         mi = tvdbp_pkg::SQ_W'(tvdbp_pkg::mag(in_im[k]));
         sq_in[k] = mr * mr + mi * mi;
      end
   end

   always_comb begin
      logic [tvdbp_pkg::SUM_W-1:0] term;
      sum_in = '0;
      for (int k = 0; k < tvdbp_pkg::NCOMP; k++) begin
         term = tvdbp_pkg::SUM_W'(sq_ff[k]);
         if (tvdbp_pkg::lane_double(s0_mode_ff, k)) term = term << 1;
         if (!tvdbp_pkg::lane_used(s0_mode_ff, k)) term = '0;
         sum_in = sum_in + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else begin
         if (en0) s0_vld_ff <= in_valid;
         if (en1) s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         s0_re_ff   <= in_re;
         s0_im_ff   <= in_im;
         s0_mode_ff <= in_mode;
         sq_ff      <= sq_in;
      end
      if (en1) begin
         s1_re_ff   <= s0_re_ff;
         s1_im_ff   <= s0_im_ff;
         s1_mode_ff <= s0_mode_ff;
         sum_ff     <= sum_in;
      end
   end

   assign out_valid = s1_vld_ff;
   assign out_re    = s1_re_ff;
   assign out_im    = s1_im_ff;
   assign out_mode  = s1_mode_ff;
   assign out_sum   = sum_ff;

endmodule

// ===== rtl/core/tvdbp_sqrt.sv =====
module tvdbp_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  tvdbp_pkg::vec_type           in_re,
   input  tvdbp_pkg::vec_type           in_im,
   input  tvdbp_pkg::mode_type          in_mode,
   input  logic [tvdbp_pkg::SUM_W-1:0]  in_sum,
   output logic                         out_valid,
   input  logic                         out_ready,
   output tvdbp_pkg::vec_type           out_re,
   output tvdbp_pkg::vec_type           out_im,
   output tvdbp_pkg::mode_type          out_mode,
   output logic [tvdbp_pkg::NORM_W-1:0] out_norm
);

   localparam int N = tvdbp_pkg::ROOT_STEPS;

   logic en [N];
   logic vld_ff [N];
   logic [tvdbp_pkg::SUM_W-1:0] v_ff [N];
   logic [tvdbp_pkg::SUM_W-1:0] root_ff [N];
   tvdbp_pkg::vec_type re_ff [N];
   tvdbp_pkg::vec_type im_ff [N];
   tvdbp_pkg::mode_type mode_ff [N];

   // one result bit per stage, test weight BIT_C falls by four each stage
   for (genvar s = 0; s < N; s++) begin : g_step
      localparam logic [tvdbp_pkg::SUM_W-1:0] BIT_C =
         tvdbp_pkg::SUM_W'(1) << (2 * (N - 1 - s));
      logic vld_pre;
      logic [tvdbp_pkg::SUM_W-1:0] v_pre, root_pre, tmp, v_in, root_in;
      tvdbp_pkg::vec_type re_pre, im_pre;
      tvdbp_pkg::mode_type mode_pre;

      if (s == 0) begin : g_first
         assign vld_pre  = in_valid;
         assign v_pre    = in_sum;
         assign root_pre = '0;
         assign re_pre   = in_re;
         assign im_pre   = in_im;
         assign mode_pre = in_mode;
      end else begin : g_next
         assign vld_pre  = vld_ff[s-1];
         assign v_pre    = v_ff[s-1];
         assign root_pre = root_ff[s-1];
         assign re_pre   = re_ff[s-1];
         assign im_pre   = im_ff[s-1];
         assign mode_pre = mode_ff[s-1];
      end

      if (s == N - 1) begin : g_last
         assign en[s] = !vld_ff[s] | out_ready;
      end else begin : g_mid
         assign en[s] = !vld_ff[s] | en[s+1];
      end

      always_comb begin
         tmp = root_pre + BIT_C;
         if (v_pre >= tmp) begin
            v_in    = v_pre - tmp;
            root_in = (root_pre >> 1) + BIT_C;
         end else begin
            v_in    = v_pre;
            root_in = root_pre >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en[s]) begin
            vld_ff[s] <= vld_pre;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            v_ff[s]    <= v_in;
            root_ff[s] <= root_in;
            re_ff[s]   <= re_pre;
            im_ff[s]   <= im_pre;
            mode_ff[s] <= mode_pre;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[N-1];
   assign out_re    = re_ff[N-1];
   assign out_im    = im_ff[N-1];
   assign out_mode  = mode_ff[N-1];
   assign out_norm  = root_ff[N-1][tvdbp_pkg::NORM_W-1:0];

endmodule

// ===== rtl/core/tvdbp_div.sv =====
module tvdbp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  tvdbp_pkg::vec_type            in_re,
   input  tvdbp_pkg::vec_type            in_im,
   input  tvdbp_pkg::mode_type           in_mode,
   input  logic [tvdbp_pkg::NORM_W-1:0]  in_norm,
   input  logic [tvdbp_pkg::SCALE_W-1:0] scale,
   output logic                          out_valid,
   input  logic                          out_ready,
   output tvdbp_pkg::vec_type            out_re,
   output tvdbp_pkg::vec_type            out_im
);

   localparam int L = tvdbp_pkg::NLANE;
   localparam int Q = tvdbp_pkg::QW;
   localparam int D = tvdbp_pkg::DEN_W;

   logic en_f0, en_f1, en_f2, en_out;
   logic en_st [Q];

   logic f0_vld_ff, f1_vld_ff, f2_vld_ff, out_vld_ff;
   tvdbp_pkg::vec_type f0_re_ff, f0_im_ff, f1_re_ff, f1_im_ff;
   tvdbp_pkg::mode_type f0_mode_ff, f1_mode_ff, f2_mode_ff;
   logic [D-1:0] prod_in, f0_prod_ff, den_in, f1_den_ff, f2_den_ff;
   logic [D-1:0] f2_rem_in [L];
   logic [D-1:0] f2_rem_ff [L];
   logic [Q-1:0] f2_low_in [L];
   logic [Q-1:0] f2_low_ff [L];
   logic [L-1:0] f2_sign_in, f2_sign_ff;

   logic st_vld_ff [Q];
   tvdbp_pkg::mode_type st_mode_ff [Q];
   logic [D-1:0] st_den_ff [Q];
   logic [L-1:0] st_sign_ff [Q];
   logic [D-1:0] st_rem_ff [Q][L];
   logic [Q-1:0] st_low_ff [Q][L];
   logic [Q-1:0] st_q_ff [Q][L];

   tvdbp_pkg::vec_type out_re_in, out_im_in, out_re_ff, out_im_ff;

   assign en_out = !out_vld_ff | out_ready;
   assign en_f2  = !f2_vld_ff | en_st[0];
   assign en_f1  = !f1_vld_ff | en_f2;
   assign en_f0  = !f0_vld_ff | en_f1;
   assign in_ready = en_f0;

   assign prod_in = D'(scale) * D'(in_norm);
   assign den_in  = (f0_prod_ff < tvdbp_pkg::DEN_ONE) ? tvdbp_pkg::DEN_ONE : f0_prod_ff;

   // numerator |c| * one + den/2, top part seeds the remainder
   always_comb begin
      tvdbp_pkg::comp_type c;
      logic [tvdbp_pkg::NUM_W-1:0] num;
      for (int l = 0; l < L; l++) begin
         c = l[0] ? f1_im_ff[l/2] : f1_re_ff[l/2];
         num = (tvdbp_pkg::NUM_W'(tvdbp_pkg::mag(c)) << tvdbp_pkg::ONE_SHIFT)
               + tvdbp_pkg::NUM_W'(f1_den_ff >> 1);
         f2_rem_in[l]  = D'(num >> Q);
         f2_low_in[l]  = num[Q-1:0];
         f2_sign_in[l] = c[tvdbp_pkg::COMP_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_vld_ff <= 1'b0;
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         if (en_f0) f0_vld_ff <= in_valid;
         if (en_f1) f1_vld_ff <= f0_vld_ff;
         if (en_f2) f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_f0) begin
         f0_re_ff   <= in_re;
         f0_im_ff   <= in_im;
         f0_mode_ff <= in_mode;
         f0_prod_ff <= prod_in;
      end
      if (en_f1) begin
         f1_re_ff   <= f0_re_ff;
         f1_im_ff   <= f0_im_ff;
         f1_mode_ff <= f0_mode_ff;
         f1_den_ff  <= den_in;
      end
      if (en_f2) begin
         f2_mode_ff <= f1_mode_ff;
         f2_den_ff  <= f1_den_ff;
         f2_rem_ff  <= f2_rem_in;
         f2_low_ff  <= f2_low_in;
         f2_sign_ff <= f2_sign_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < Q; s++) begin : g_step
      logic vld_pre;
      tvdbp_pkg::mode_type mode_pre;
      logic [D-1:0] den_pre;
      logic [L-1:0] sign_pre;
      logic [D-1:0] rem_pre [L];
      logic [Q-1:0] low_pre [L];
      logic [Q-1:0] q_pre [L];
      logic [D-1:0] rem_in [L];
      logic [Q-1:0] low_in [L];
      logic [Q-1:0] q_in [L];

      if (s == 0) begin : g_first
         assign vld_pre  = f2_vld_ff;
         assign mode_pre = f2_mode_ff;
         assign den_pre  = f2_den_ff;
         assign sign_pre = f2_sign_ff;
         assign rem_pre  = f2_rem_ff;
         assign low_pre  = f2_low_ff;
         always_comb begin
            for (int l = 0; l < L; l++) q_pre[l] = '0;
         end
      end else begin : g_next
         assign vld_pre  = st_vld_ff[s-1];
         assign mode_pre = st_mode_ff[s-1];
         assign den_pre  = st_den_ff[s-1];
         assign sign_pre = st_sign_ff[s-1];
         assign rem_pre  = st_rem_ff[s-1];
         assign low_pre  = st_low_ff[s-1];
         assign q_pre    = st_q_ff[s-1];
      end

      if (s == Q - 1) begin : g_last
         assign en_st[s] = !st_vld_ff[s] | en_out;
      end else begin : g_mid
         assign en_st[s] = !st_vld_ff[s] | en_st[s+1];
      end

      always_comb begin
         logic [D:0] r2;
         for (int l = 0; l < L; l++) begin
            r2 = {rem_pre[l], low_pre[l][Q-1]};
            low_in[l] = low_pre[l] << 1;
            if (r2 >= {1'b0, den_pre}) begin
               rem_in[l] = D'(r2 - {1'b0, den_pre});
               q_in[l]   = {q_pre[l][Q-2:0], 1'b1};
            end else begin
               rem_in[l] = D'(r2);
               q_in[l]   = {q_pre[l][Q-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_vld_ff[s] <= 1'b0;
         end else if (en_st[s]) begin
            st_vld_ff[s] <= vld_pre;
         end
      end

      always_ff @(posedge clock) begin
         if (en_st[s]) begin
            st_mode_ff[s] <= mode_pre;
            st_den_ff[s]  <= den_pre;
            st_sign_ff[s] <= sign_pre;
            st_rem_ff[s]  <= rem_in;
            st_low_ff[s]  <= low_in;
            st_q_ff[s]    <= q_in;
         end
      end
   end

   // sign, saturation, unused components forced to zero
   always_comb begin
      logic [Q-1:0] q;
      logic [Q-1:0] m;
      tvdbp_pkg::comp_type r;
      out_re_in = '0;
      out_im_in = '0;
      for (int l = 0; l < L; l++) begin
         q = st_q_ff[Q-1][l];
         if (st_sign_ff[Q-1][l]) begin
            m = (q > tvdbp_pkg::NEG_MAX) ? tvdbp_pkg::NEG_MAX : q;
            r = tvdbp_pkg::comp_type'(-m);
         end else begin
            m = (q > tvdbp_pkg::POS_MAX) ? tvdbp_pkg::POS_MAX : q;
            r = tvdbp_pkg::comp_type'(m);
         end
         if (!tvdbp_pkg::lane_used(st_mode_ff[Q-1], l / 2)) r = '0;
         if (l[0]) out_im_in[l/2] = r;
         else      out_re_in[l/2] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en_out) begin
         out_vld_ff <= st_vld_ff[Q-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_re    = out_re_ff;
   assign out_im    = out_im_ff;

endmodule
